// ----- sv/atc_pkg.sv -----
// ----------------------------------------------------------------------------
// atc_pkg
// Types, widths and nearness helpers shared by the affine classifier blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package atc_pkg;

    // Field widths fixed by the item format
    localparam int COEF_W = 32;
    localparam int TOL_W  = 31;
    localparam int DET_W  = 64;
    localparam int DIFF_W = COEF_W + 2;

    // One input item: six coefficients
    typedef struct packed {
        logic signed [COEF_W-1:0] x_axis_x;
        logic signed [COEF_W-1:0] x_axis_y;
        logic signed [COEF_W-1:0] y_axis_x;
        logic signed [COEF_W-1:0] y_axis_y;
        logic signed [COEF_W-1:0] shift_x;
        logic signed [COEF_W-1:0] shift_y;
    } t_coef;

    // Coefficient-format nearness tests, worked out in the product stage
    typedef struct packed {
        logic n0one;     // c0 near 1.0
        logic n3one;     // c3 near 1.0
        logic n1z;       // c1 near 0
        logic n2z;       // c2 near 0
        logic n4z;       // c4 near 0
        logic n5z;       // c5 near 0
        logic abs_eq;    // |c0| near |c3|
        logic n03;       // c0 near c3
        logic n1m2;      // c1 near -c2
        logic n0m3;      // c0 near -c3
        logic n12;       // c1 near c2
    } t_coef_flags;

    // Exact products, Q32.32
    typedef struct packed {
        logic signed [DET_W-1:0] p03;
        logic signed [DET_W-1:0] p12;
        logic signed [DET_W-1:0] p00;
        logic signed [DET_W-1:0] p11;
    } t_prod;

    // One result item
    typedef struct packed {
        logic signed [DET_W-1:0] determinant;
        logic                    is_identity;
        logic [1:0]              translation_flags;
        logic [3:0]              scale_flags;
        logic [2:0]              rotation_flags;
        logic [3:0]              shear_flags;
        logic [2:0]              preserve_flags;
        logic                    is_zoom;
        logic                    is_singular;
        logic                    flips;
    } t_result;

    // Sign-extend a coefficient to the difference width
    function automatic logic signed [DIFF_W-1:0] ext_c(input logic signed [COEF_W-1:0] c);
        return {{(DIFF_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

    // |a - b| <= tol in coefficient format
    function automatic logic near_c(input logic signed [DIFF_W-1:0] a,
                                    input logic signed [DIFF_W-1:0] b,
                                    input logic [TOL_W-1:0]         tol);
        logic signed [DIFF_W-1:0] d;
        logic        [DIFF_W-1:0] m;
        d = a - b;
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m <= {{(DIFF_W-TOL_W){1'b0}}, tol};
    endfunction

    // |u - w| <= tol on unsigned product-format magnitudes
    function automatic logic near_u(input logic [DET_W-1:0] u,
                                    input logic [DET_W-1:0] w,
                                    input logic [DET_W-1:0] tol);
        logic [DET_W-1:0] d;
        d = (u >= w) ? (u - w) : (w - u);
        return d <= tol;
    endfunction

endpackage

`default_nettype wire

// ----- sv/atc_ifs.sv -----
// ----------------------------------------------------------------------------
// atc_ifs
// Valid/ready channels of the affine classifier: coefficients, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

// Coefficient item channel
interface atc_coef_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_axis_x;
    logic signed [31:0] x_axis_y;
    logic signed [31:0] y_axis_x;
    logic signed [31:0] y_axis_y;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;

    modport source (output valid, x_axis_x, x_axis_y, y_axis_x, y_axis_y,
                    shift_x, shift_y, input ready);
    modport sink   (input valid, x_axis_x, x_axis_y, y_axis_x, y_axis_y,
                    shift_x, shift_y, output ready);
endinterface

// Result item channel
interface atc_res_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] determinant;
    logic               is_identity;
    logic [1:0]         translation_flags;
    logic [3:0]         scale_flags;
    logic [2:0]         rotation_flags;
    logic [3:0]         shear_flags;
    logic [2:0]         preserve_flags;
    logic               is_zoom;
    logic               is_singular;
    logic               flips;

    modport source (output valid, determinant, is_identity, translation_flags,
                    scale_flags, rotation_flags, shear_flags, preserve_flags,
                    is_zoom, is_singular, flips, input ready);
    modport sink   (input valid, determinant, is_identity, translation_flags,
                    scale_flags, rotation_flags, shear_flags, preserve_flags,
                    is_zoom, is_singular, flips, output ready);
endinterface

// Tolerance write channel
interface atc_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] tolerance;

    modport source (output valid, tolerance, input ready);
    modport sink   (input valid, tolerance, output ready);
endinterface

`default_nettype wire

// ----- sv/affine_transform_classifier_top.sv -----
// ----------------------------------------------------------------------------
// affine_transform_classifier_top
// Classifies 2D affine transforms: exact determinant and predicate flags.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake     Payload
//  i_coef    in   valid/ready   six Q16.16 coefficients
//  o_res     out  valid/ready   determinant (Q32.32) and classification flags
//  i_cfg     in   valid/ready   tolerance (31 bit), ready always high
//
//  One item per cycle sustained while o_res.ready stays high; an accepted item
//  passes the input, product and result registers before o_res.valid rises.
//  The product register splits the 32x32 multipliers from the 64 bit
//  determinant and compares.
//  Every stage takes a new item when it is empty or its contents move on,
//  so bubbles close up and input is still taken while a result waits, until
//  all three registers hold items.
//  Synchronous active-low reset clears all stage valids; tolerance resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_transform_classifier_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    atc_coef_if.sink      i_coef,
    atc_res_if.source     o_res,
    atc_cfg_if.sink       i_cfg
);
    import atc_pkg::*;

    logic             r_in_valid;
    t_coef            r_coef;
    logic [TOL_W-1:0] r_tol;
    logic             prod_ready, prod_valid, dec_ready;
    t_prod            prod;
    t_coef_flags      flags;
    t_result          result;

    // Tolerance register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.tolerance;
        end
    end

    // Input register
    assign i_coef.ready = !r_in_valid || prod_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_coef.ready) begin
            r_in_valid <= i_coef.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_coef.ready && i_coef.valid) begin
            r_coef.x_axis_x <= i_coef.x_axis_x;
            r_coef.x_axis_y <= i_coef.x_axis_y;
            r_coef.y_axis_x <= i_coef.y_axis_x;
            r_coef.y_axis_y <= i_coef.y_axis_y;
            r_coef.shift_x  <= i_coef.shift_x;
            r_coef.shift_y  <= i_coef.shift_y;
        end
    end

    // Products and coefficient tests
    atc_prod_stage #(.FRAC_BITS(FRAC_BITS)) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (prod_ready),
        .i_coef  (r_coef),
        .i_tol   (r_tol),
        .o_valid (prod_valid),
        .i_ready (dec_ready),
        .o_prod  (prod),
        .o_flags (flags)
    );

    // Determinant and flag assembly
    atc_decide_stage #(.FRAC_BITS(FRAC_BITS)) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (prod_valid),
        .o_ready  (dec_ready),
        .i_prod   (prod),
        .i_flags  (flags),
        .i_tol    (r_tol),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (result)
    );

    // Result fields
    assign o_res.determinant       = result.determinant;
    assign o_res.is_identity       = result.is_identity;
    assign o_res.translation_flags = result.translation_flags;
    assign o_res.scale_flags       = result.scale_flags;
    assign o_res.rotation_flags    = result.rotation_flags;
    assign o_res.shear_flags       = result.shear_flags;
    assign o_res.preserve_flags    = result.preserve_flags;
    assign o_res.is_zoom           = result.is_zoom;
    assign o_res.is_singular       = result.is_singular;
    assign o_res.flips             = result.flips;

endmodule

`default_nettype wire

// ----- sv/atc_prod_stage.sv -----
// ----------------------------------------------------------------------------
// atc_prod_stage
// Four 32x32 signed products and the coefficient nearness tests, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_prod_stage #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  atc_pkg::t_coef               i_coef,
    input  wire [atc_pkg::TOL_W-1:0]     i_tol,
    output logic                         o_valid,
    input  wire                          i_ready,
    output atc_pkg::t_prod               o_prod,
    output atc_pkg::t_coef_flags         o_flags
);
    import atc_pkg::*;

    localparam logic signed [DIFF_W-1:0] ONE = DIFF_W'(1) <<< FRAC_BITS;

    logic                     r_valid;
    t_prod                    r_prod;
    t_coef_flags              r_flags;
    t_prod                    n_prod;
    t_coef_flags              n_flags;
    logic signed [DIFF_W-1:0] c0, c1, c2, c3, c4, c5, a0, a3;

    assign o_ready = !r_valid || i_ready;

    // Products and nearness tests
    always_comb begin
        c0 = ext_c(i_coef.x_axis_x);
        c1 = ext_c(i_coef.x_axis_y);
        c2 = ext_c(i_coef.y_axis_x);
        c3 = ext_c(i_coef.y_axis_y);
        c4 = ext_c(i_coef.shift_x);
        c5 = ext_c(i_coef.shift_y);
        a0 = c0[DIFF_W-1] ? -c0 : c0;
        a3 = c3[DIFF_W-1] ? -c3 : c3;

        n_prod.p03 = DET_W'($signed(64'(i_coef.x_axis_x)) * $signed(64'(i_coef.y_axis_y)));
        n_prod.p12 = DET_W'($signed(64'(i_coef.x_axis_y)) * $signed(64'(i_coef.y_axis_x)));
        n_prod.p00 = DET_W'($signed(64'(i_coef.x_axis_x)) * $signed(64'(i_coef.x_axis_x)));
        n_prod.p11 = DET_W'($signed(64'(i_coef.x_axis_y)) * $signed(64'(i_coef.x_axis_y)));

        n_flags.n0one  = near_c(c0, ONE, i_tol);
        n_flags.n3one  = near_c(c3, ONE, i_tol);
        n_flags.n1z    = near_c(c1, '0, i_tol);
        n_flags.n2z    = near_c(c2, '0, i_tol);
        n_flags.n4z    = near_c(c4, '0, i_tol);
        n_flags.n5z    = near_c(c5, '0, i_tol);
        n_flags.abs_eq = near_c(a0, a3, i_tol);
        n_flags.n03    = near_c(c0, c3, i_tol);
        n_flags.n1m2   = near_c(c1, -c2, i_tol);
        n_flags.n0m3   = near_c(c0, -c3, i_tol);
        n_flags.n12    = near_c(c1, c2, i_tol);
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod  <= n_prod;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

// ----- sv/atc_decide_stage.sv -----
// ----------------------------------------------------------------------------
// atc_decide_stage
// Determinant, product-format tests and flag assembly into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module atc_decide_stage #(
    parameter int FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  atc_pkg::t_prod               i_prod,
    input  atc_pkg::t_coef_flags         i_flags,
    input  wire [atc_pkg::TOL_W-1:0]     i_tol,
    output logic                         o_valid,
    input  wire                          i_ready,
    output atc_pkg::t_result             o_result
);
    import atc_pkg::*;

    localparam logic [DET_W-1:0] ONE2 = DET_W'(1) << (2 * FRAC_BITS);

    logic                    r_valid;
    t_result                 r_result;
    t_result                 n_result;
    logic signed [DET_W:0]   det_x;
    logic signed [DET_W-1:0] det;
    logic [DET_W-1:0]        adet, sq, tol2;
    logic singular, unit_len, no_shift, off_zero, rot_form, refl_form;
    logic transl, scale, uscale, rot_any, rot, hsh, vsh;

    assign o_ready = !r_valid || i_ready;

    // Wide arithmetic and predicates
    always_comb begin
        det_x = {i_prod.p03[DET_W-1], i_prod.p03} - {i_prod.p12[DET_W-1], i_prod.p12};
        det   = det_x[DET_W-1:0];
        adet  = det[DET_W-1] ? (DET_W'(0) - DET_W'(det)) : DET_W'(det);
        sq    = DET_W'(i_prod.p00) + DET_W'(i_prod.p11);
        tol2  = {{(DET_W-TOL_W){1'b0}}, i_tol} << FRAC_BITS;

        singular  = adet <= tol2;
        unit_len  = near_u(sq, ONE2, tol2);
        no_shift  = i_flags.n4z && i_flags.n5z;
        off_zero  = i_flags.n1z && i_flags.n2z;
        rot_form  = i_flags.n03 && i_flags.n1m2;
        refl_form = i_flags.n0m3 && i_flags.n12;

        transl  = i_flags.n0one && off_zero && i_flags.n3one;
        scale   = !singular && off_zero && no_shift;
        uscale  = scale && i_flags.abs_eq;
        rot_any = rot_form && unit_len;
        rot     = rot_any && no_shift;
        hsh     = i_flags.n0one && i_flags.n1z && i_flags.n3one && no_shift;
        vsh     = i_flags.n0one && i_flags.n2z && i_flags.n3one && no_shift;

        n_result.determinant       = det;
        n_result.is_identity       = transl && no_shift;
        n_result.translation_flags = {transl && !no_shift, transl};
        n_result.scale_flags       = {uscale && !(i_flags.n0one && i_flags.n3one), uscale,
                                      scale && (!i_flags.n0one || !i_flags.n3one), scale};
        n_result.rotation_flags    = {rot_any && !i_flags.n0one, rot && !i_flags.n0one, rot};
        n_result.shear_flags       = {vsh && !i_flags.n1z, vsh, hsh && !i_flags.n2z, hsh};
        n_result.preserve_flags    = {(rot_form || refl_form) && unit_len,
                                      !singular && (rot_form || refl_form),
                                      near_u(adet, ONE2, tol2)};
        n_result.is_zoom           = !singular && i_flags.n03 && off_zero;
        n_result.is_singular       = singular;
        n_result.flips             = det[DET_W-1];
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Identity is a special translation
    a_ident_transl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.is_identity |-> r_result.translation_flags[0])
        else $error("identity without translation flag");

    // Singular matrices are never scales, zooms or angle-preserving
    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.is_singular |->
            (r_result.scale_flags == 4'd0) && !r_result.is_zoom &&
            !r_result.preserve_flags[1])
        else $error("singular matrix with scale, zoom or angle flag");

    // Nonzero variants imply the base predicate
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (!r_result.rotation_flags[1] || r_result.rotation_flags[0]) &&
                    (!r_result.shear_flags[1] || r_result.shear_flags[0]) &&
                    (!r_result.shear_flags[3] || r_result.shear_flags[2]) &&
                    (!r_result.scale_flags[3] || r_result.scale_flags[2]))
        else $error("nonzero flag without its base flag");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_result))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

// ----- test/affine_transform_classifier_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_transform_classifier_top_tb
// Self-checking bench for the affine transform classifier. Matrices are fed
// through the coefficient channel from a queue. The bench works out the
// determinant and every flag at the moment each item is accepted. Results
// are checked in order, field by field, under several tolerance settings.
// Sender and receiver both idle in random bursts.
// ----------------------------------------------------------------------------

module affine_transform_classifier_top_tb;

    import atc_pkg::*;

    localparam int     FRAC           = 16;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     END_SLACK      = 8;
    localparam int     MAX_PRINTS     = 60;
    localparam int     ONE            = 32'sh0001_0000;
    localparam int     CMIN           = 32'sh8000_0000;
    localparam int     CMAX           = 32'sh7FFF_FFFF;
    localparam real    PI             = 3.14159265358979;

    // Shapes of generated matrices
    typedef enum int {
        MK_NOISE, MK_SMALL, MK_TRANSLATE, MK_SCALE, MK_ROTATE,
        MK_REFLECT, MK_SHEAR, MK_SINGULAR, MK_CORNER
    } matrix_kind_e;

    logic        clk;
    logic        rst_n     = 1'b0;
    t_coef       coef_drv  = '0;
    logic        coef_valid = 1'b0;
    logic        res_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [30:0] cfg_tol   = 31'd1;

    atc_coef_if coef_if ();
    atc_res_if  res_if ();
    atc_cfg_if  cfg_if ();

    assign coef_if.valid = coef_valid;
    assign {coef_if.x_axis_x, coef_if.x_axis_y, coef_if.y_axis_x,
            coef_if.y_axis_y, coef_if.shift_x, coef_if.shift_y} = coef_drv;
    assign res_if.ready     = res_ready;
    assign cfg_if.valid     = cfg_valid;
    assign cfg_if.tolerance = cfg_tol;

    affine_transform_classifier_top #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_coef  (coef_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_coef       matrix_queue[$];
    t_result     predicted_results[$];
    logic [30:0] tol_now = 31'd1;
    logic        idling_on = 1'b1;
    int          error_count = 0;
    int          items_accepted = 0;
    int          results_checked = 0;
    int          tol_settings = 1;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          quiet_cycles = 0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Classification predictor
    // ------------------------------------------------------------------------
    function automatic logic coef_close(input longint a, input longint b, input longint eps);
        longint d;
        d = a - b;
        return ((d < 0) ? -d : d) <= eps;
    endfunction

    function automatic logic mag_close(input logic [63:0] u, input logic [63:0] w,
                                       input logic [63:0] eps);
        logic [63:0] d;
        d = (u >= w) ? (u - w) : (w - u);
        return d <= eps;
    endfunction

    function automatic t_result classify_matrix(input t_coef m, input logic [30:0] tol);
        t_result     r;
        longint      c0, c1, c2, c3, c4, c5, det, eps, one_c;
        logic [63:0] abs_det, len_sq, eps_q, one_q;
        logic        singular, unit_len, a_one, d_one, b_zero, c_zero, no_shift;
        logic        abs_match, rot_shape, refl_shape, transl, scale, uscale;
        logic        rot_any, rot, hsh, vsh;
        c0 = m.x_axis_x;
        c1 = m.x_axis_y;
        c2 = m.y_axis_x;
        c3 = m.y_axis_y;
        c4 = m.shift_x;
        c5 = m.shift_y;
        eps   = longint'(tol);
        one_c = longint'(1) << FRAC;
        eps_q = 64'(tol) << FRAC;
        one_q = 64'd1 << (2 * FRAC);

        // exact Q32.32 products
        det     = c0 * c3 - c1 * c2;
        abs_det = (det < 0) ? 64'(-det) : 64'(det);
        len_sq  = 64'(c0 * c0) + 64'(c1 * c1);

        singular   = abs_det <= eps_q;
        unit_len   = mag_close(len_sq, one_q, eps_q);
        a_one      = coef_close(c0, one_c, eps);
        d_one      = coef_close(c3, one_c, eps);
        b_zero     = coef_close(c1, 0, eps);
        c_zero     = coef_close(c2, 0, eps);
        no_shift   = coef_close(c4, 0, eps) && coef_close(c5, 0, eps);
        abs_match  = coef_close((c0 < 0) ? -c0 : c0, (c3 < 0) ? -c3 : c3, eps);
        rot_shape  = coef_close(c0, c3, eps) && coef_close(c1, -c2, eps);
        refl_shape = coef_close(c0, -c3, eps) && coef_close(c1, c2, eps);

        transl  = a_one && b_zero && c_zero && d_one;
        scale   = !singular && b_zero && c_zero && no_shift;
        uscale  = scale && abs_match;
        rot_any = rot_shape && unit_len;
        rot     = rot_any && no_shift;
        hsh     = a_one && b_zero && d_one && no_shift;
        vsh     = a_one && c_zero && d_one && no_shift;

        r.determinant       = det;
        r.is_identity       = transl && no_shift;
        r.translation_flags = {transl && !no_shift, transl};
        r.scale_flags       = {uscale && !(a_one && d_one), uscale,
                               scale && (!a_one || !d_one), scale};
        r.rotation_flags    = {rot_any && !a_one, rot && !a_one, rot};
        r.shear_flags       = {vsh && !b_zero, vsh, hsh && !c_zero, hsh};
        r.preserve_flags    = {(rot_shape || refl_shape) && unit_len,
                               !singular && (rot_shape || refl_shape),
                               mag_close(abs_det, one_q, eps_q)};
        r.is_zoom           = !singular && coef_close(c0, c3, eps) && b_zero && c_zero;
        r.is_singular       = singular;
        r.flips             = det < 0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Matrix generation
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] jitter(input longint centre, input longint span);
        return 32'(centre + longint'($urandom_range(0, 32'(2 * span + 2))) - span - 1);
    endfunction

    // roughly +/- 4.0
    function automatic logic signed [31:0] small_coef();
        return 32'(longint'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic logic signed [31:0] pick_shift(input longint span);
        if ($urandom_range(0, 3) != 0)
            return jitter(0, span);
        return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_corner();
        case ($urandom_range(0, 6))
            0: return CMIN;
            1: return CMAX;
            2: return 0;
            3: return ONE;
            4: return -ONE;
            5: return 1;
            default: return -1;
        endcase
    endfunction

    function automatic t_coef make_matrix(input matrix_kind_e kind, input logic [30:0] tol);
        t_coef  m;
        longint sp, a, b, k, cs, sn;
        real    th, x;
        sp = (tol > 31'd50000) ? 64'd50000 : longint'(tol);
        m  = '0;
        if ($urandom_range(0, 3) == 0)
            th = $urandom_range(0, 3) * PI / 2.0;
        else
            th = $urandom_range(0, 3599) * PI / 1800.0;
        x  = $cos(th) * 65536.0;
        cs = $rtoi(x + ((x >= 0.0) ? 0.5 : -0.5));
        x  = $sin(th) * 65536.0;
        sn = $rtoi(x + ((x >= 0.0) ? 0.5 : -0.5));
        case (kind)
            MK_NOISE: begin
                m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end
            MK_SMALL: begin
                m = {small_coef(), small_coef(), small_coef(), small_coef(),
                     small_coef(), small_coef()};
            end
            MK_TRANSLATE: begin
                m = {jitter(ONE, sp), jitter(0, sp), jitter(0, sp), jitter(ONE, sp),
                     pick_shift(sp), pick_shift(sp)};
            end
            MK_SCALE: begin
                a = small_coef();
                case ($urandom_range(0, 3))
                    0: b = a;
                    1: b = -a;
                    2: b = jitter(a, sp);
                    default: b = small_coef();
                endcase
                m = {32'(a), jitter(0, sp), jitter(0, sp), 32'(b),
                     pick_shift(sp), pick_shift(sp)};
            end
            MK_ROTATE: begin
                m = {jitter(cs, sp), jitter(sn, sp), jitter(-sn, sp), jitter(cs, sp),
                     pick_shift(sp), pick_shift(sp)};
            end
            MK_REFLECT: begin
                m = {jitter(cs, sp), jitter(sn, sp), jitter(sn, sp), jitter(-cs, sp),
                     pick_shift(sp), pick_shift(sp)};
            end
            MK_SHEAR: begin
                if ($urandom_range(0, 1) != 0)
                    m = {jitter(ONE, sp), jitter(0, sp), small_coef(), jitter(ONE, sp),
                         pick_shift(sp), pick_shift(sp)};
                else
                    m = {jitter(ONE, sp), small_coef(), jitter(0, sp), jitter(ONE, sp),
                         pick_shift(sp), pick_shift(sp)};
            end
            MK_SINGULAR: begin
                // proportional rows, sometimes nudged off by one
                a = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
                b = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
                k = longint'($urandom_range(0, 8)) - 4;
                m = {32'(a), 32'(b), 32'(k * a),
                     32'(k * b + (($urandom_range(0, 1) != 0) ?
                                  longint'($urandom_range(0, 2)) - 1 : 0)),
                     pick_shift(sp), pick_shift(sp)};
            end
            default: begin
                m = {pick_corner(), pick_corner(), pick_corner(), pick_corner(),
                     pick_corner(), pick_corner()};
            end
        endcase
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s got %h want %h",
                                   results_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued matrices, idles in bursts between items
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            coef_valid <= 1'b0;
            coef_drv   <= '0;
            send_gap   = 0;
        end else begin
            if (coef_valid && coef_if.ready) begin
                predicted_results.push_back(classify_matrix(coef_drv, tol_now));
                items_accepted++;
            end
            if (!coef_valid || coef_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    coef_valid <= 1'b0;
                end else if (matrix_queue.size() > 0) begin
                    coef_drv   <= matrix_queue.pop_front();
                    coef_valid <= 1'b1;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 6);
                end else begin
                    coef_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_result got, want;
        if (!rst_n) begin
            res_ready <= 1'b0;
            recv_gap  = 0;
        end else begin
            if (res_if.valid && res_ready) begin
                got = {res_if.determinant, res_if.is_identity, res_if.translation_flags,
                       res_if.scale_flags, res_if.rotation_flags, res_if.shear_flags,
                       res_if.preserve_flags, res_if.is_zoom, res_if.is_singular,
                       res_if.flips};
                if (predicted_results.size() == 0) begin
                    report_error($sformatf("unexpected result, determinant %h",
                                           got.determinant));
                end else begin
                    want = predicted_results.pop_front();
                    check_field("determinant", got.determinant, want.determinant);
                    check_field("is_identity", got.is_identity, want.is_identity);
                    check_field("translation_flags", got.translation_flags,
                                want.translation_flags);
                    check_field("scale_flags", got.scale_flags, want.scale_flags);
                    check_field("rotation_flags", got.rotation_flags, want.rotation_flags);
                    check_field("shear_flags", got.shear_flags, want.shear_flags);
                    check_field("preserve_flags", got.preserve_flags, want.preserve_flags);
                    check_field("is_zoom", got.is_zoom, want.is_zoom);
                    check_field("is_singular", got.is_singular, want.is_singular);
                    check_field("flips", got.flips, want.flips);
                end
                results_checked++;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    recv_gap = $urandom_range(1, 6);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any item moving on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((coef_valid && coef_if.ready) || (res_if.valid && res_ready) ||
                     (cfg_valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                     quiet_cycles, predicted_results.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------
    task automatic queue_matrix(input int c0, input int c1, input int c2,
                                input int c3, input int c4, input int c5);
        matrix_queue.push_back({c0, c1, c2, c3, c4, c5});
    endtask

    // block idle: nothing queued, nothing presented, nothing outstanding
    task automatic wait_drained();
        do
            @(negedge clk);
        while (matrix_queue.size() != 0 || coef_valid || predicted_results.size() != 0);
    endtask

    task automatic write_tolerance(input logic [30:0] tol);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_tol   <= tol;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        tol_now = tol;
        tol_settings++;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            matrix_queue.push_back(
                make_matrix(matrix_kind_e'($urandom_range(MK_NOISE, MK_CORNER)), tol_now));
    endtask

    // one tolerance setting; halfway through the sender holds off until drained
    task automatic run_phase(input logic [30:0] tol, input int count, input logic idle);
        write_tolerance(tol);
        idling_on = idle;
        queue_random(count / 2);
        wait_drained();
        queue_random(count - count / 2);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners under the reset tolerance
        queue_matrix(ONE, 0, 0, ONE, 0, 0);                  // identity
        queue_matrix(ONE, 0, 0, ONE, 5 * ONE, -3 * ONE);     // translation only
        queue_matrix(0, 0, 0, 0, 0, 0);                      // all zero
        queue_matrix(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        queue_matrix(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        queue_matrix(CMIN, CMIN, CMAX, CMIN, CMAX, CMIN);    // largest determinant
        queue_matrix(CMAX, CMIN, CMIN, CMAX, 0, 0);          // negative determinant
        queue_matrix(CMIN, 0, 0, CMIN, 0, 0);                // extreme uniform scale
        queue_matrix(2 * ONE, 0, 0, 3 * ONE, 0, 0);          // non-uniform scale
        queue_matrix(2 * ONE, 0, 0, 2 * ONE, 0, 0);          // zoom
        queue_matrix(-2 * ONE, 0, 0, 2 * ONE, 0, 0);         // mirrored scale
        queue_matrix(0, ONE, -ONE, 0, 0, 0);                 // quarter turn
        queue_matrix(0, ONE, -ONE, 0, ONE, 2 * ONE);         // quarter turn, shifted
        queue_matrix(39322, 52429, -52429, 39322, 0, 0);     // 3-4-5 rotation
        queue_matrix(-ONE, 0, 0, -ONE, 0, 0);                // half turn
        queue_matrix(ONE, 0, 0, -ONE, 0, 0);                 // reflection
        queue_matrix(ONE, 0, ONE / 2, ONE, 0, 0);            // horizontal shear
        queue_matrix(ONE, ONE / 2, 0, ONE, 0, 0);            // vertical shear
        queue_matrix(ONE, 0, 3 * ONE, ONE, 7, -7);           // shear off origin
        queue_matrix(ONE + 1, 1, -1, ONE - 1, 1, -1);        // at the tolerance edge
        queue_matrix(ONE + 2, 2, 0, ONE, 0, -2);             // just past it
        queue_matrix(ONE, 2 * ONE, 2 * ONE, 4 * ONE, 0, 0);  // singular, non-zero
        queue_matrix(1, 1, 2, 1, 0, 0);                      // tiny negative determinant
        wait_drained();

        run_phase(31'd0, 300, 1'b1);
        run_phase(31'($urandom_range(1, 16'hFFFF)), 400, 1'b1);
        run_phase(31'h7FFF_FFFF, 200, 1'b1);
        run_phase(31'($urandom), 200, 1'b0);
        run_phase(31'd16, 400, 1'b1);
        // closing stretch at full rate on both sides
        run_phase(31'($urandom_range(1, 255)), 500, 1'b0);

        repeat (END_SLACK) @(posedge clk);
        $display("checked %0d results from %0d matrices over %0d tolerance settings",
                 results_checked, items_accepted, tol_settings);
        $display("corners, structured shapes near the tolerance and random noise, %0d errors",
                 error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
